// File: rtl/wsm_pkg.sv
`default_nettype none
package wsm_pkg;

  parameter int MAX_INNER_DEF = 64;
  parameter int MAX_COLS_DEF  = 64;

  localparam int DIM_LIMIT = 1024;
  localparam int KIDX_W    = 8;   // wide enough for MAX_INNER up to 256
  localparam int ACC_W     = 38;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_STREAM = 1'b1;

  localparam logic [1:0] REG_ROWS_M      = 2'd0;
  localparam logic [1:0] REG_INNER_K     = 2'd1;
  localparam logic [1:0] REG_COLS_N      = 2'd2;
  localparam logic [1:0] REG_BATCH_COUNT = 2'd3;

  typedef struct packed {
    logic               command;
    logic [5:0]         inner_index;
    logic [5:0]         column_index;
    logic signed [15:0] operand_value;
  } op_t;

  typedef struct packed {
    logic signed [37:0] product_sum;
    logic [9:0]         out_row;
    logic [5:0]         out_column;
    logic               last_of_row;
    logic               last_of_batch;
  } out_t;

  // Request moving down the cell chain.
  typedef struct packed {
    logic               valid;
    logic               write;
    logic               last;
    logic [KIDX_W-1:0]  k;
    logic [5:0]         col;
    logic signed [15:0] value;
  } tok_t;

  // Finished column sum moving back toward cell 0.
  typedef struct packed {
    logic               valid;
    logic signed [37:0] sum;
  } link_t;

endpackage
`default_nettype wire

// File: rtl/wsm_cell.sv
`default_nettype none
module wsm_cell #(
  parameter int MAX_INNER = wsm_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = wsm_pkg::MAX_COLS_DEF,
  parameter int COL       = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [6:0]    ncols,
  input  wire wsm_pkg::tok_t tok_in,
  output wsm_pkg::tok_t      tok_out,
  input  wire wsm_pkg::link_t res_in,
  output wsm_pkg::link_t     res_out
);

  localparam int KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  logic signed [15:0] wmem [MAX_INNER];
  logic signed [15:0] wdata;
  logic signed [15:0] a1;
  logic               act1, last1;
  logic signed [31:0] prod;
  logic               act2, last2;
  logic signed [37:0] acc;
  logic signed [37:0] sum;
  logic [KW-1:0]      addr;
  logic               mine;
  logic               use_col;
  logic               emit;

  assign addr    = tok_in.k[KW-1:0];
  assign mine    = ({1'b0, tok_in.col} == 7'(COL)) && (COL < MAX_COLS);
  assign use_col = 7'(COL) < ncols;
  assign sum     = acc + {{6{prod[31]}}, prod};
  assign emit    = act2 && last2 && use_col;

  // Weight column of this cell.
  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.write && mine) begin
      wmem[addr] <= tok_in.value;
    end
    if (tok_in.valid && !tok_in.write) begin
      wdata <= wmem[addr];
    end
    a1   <= tok_in.value;
    prod <= wdata * a1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      act1          <= 1'b0;
      act2          <= 1'b0;
      res_out.valid <= 1'b0;
      acc           <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      act1          <= tok_in.valid && !tok_in.write;
      act2          <= act1;
      res_out.valid <= emit || res_in.valid;
      if (act2) begin
        if (last2) begin
          acc <= '0;
        end else if (use_col) begin
          acc <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out.write <= tok_in.write;
    tok_out.last  <= tok_in.last;
    tok_out.k     <= tok_in.k;
    tok_out.col   <= tok_in.col;
    tok_out.value <= tok_in.value;
    last1         <= tok_in.last;
    last2         <= last1;
    res_out.sum   <= emit ? sum : res_in.sum;
  end

endmodule
`default_nettype wire

// File: rtl/weight_stationary_matmul.sv
`default_nettype none
// Weight-stationary matrix multiply, C = A x B with one B per batch.
// op channel (op_valid / op_stall / op): command OP_WRITE stores one Q8.8
// element of B at (inner_index, column_index); command OP_STREAM feeds one
// element A[row][inner_index]. A request is taken when op_valid is high and
// op_stall low. Writes and streamed elements that do not end a row flow in
// at one per cycle unless stalled. A streamed element with the last inner
// index closes the row: op_stall is set until its cols_n sums are taken.
// res channel (res_valid / res_stall / res): one exact Q22.16 sum per column,
// in column order, tagged with row, column, last_of_row and last_of_batch.
// Column 0 reaches res first and the other columns follow in order, since
// each further column's request walks one more cell down the chain and
// its sum one more cell back. A full row holds the input until its last
// sum is taken; any res_stall stretches this and the payload holds.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// rows_m, inner_k, cols_n, batch_count; always ready, write it while idle.
// Reset (rst, synchronous) clears accumulators, row/matrix counters and sets
// all registers to 1. B stays undefined until written.
module weight_stationary_matmul #(
  parameter int MAX_INNER = wsm_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = wsm_pkg::MAX_COLS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  output logic              op_stall,
  input  wire wsm_pkg::op_t op,
  output logic              res_valid,
  input  wire logic         res_stall,
  output wsm_pkg::out_t     res,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [10:0]  cfg_data
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Configuration registers.
  logic [10:0] rows_m;
  logic [6:0]  inner_k;
  logic [6:0]  cols_n;
  logic [10:0] batch_count;

  // Effective (clamped) dimensions.
  logic [8:0]  kk;
  logic [6:0]  nn;
  logic [10:0] mm;
  logic [10:0] bb;

  logic [9:0]  row_counter;
  logic [9:0]  matrix_counter;
  logic [9:0]  row_tag;
  logic        batch_end;
  logic        busy;
  logic [6:0]  rcv_cnt;
  logic [6:0]  rd_col;
  logic        load;

  logic        accept;
  logic        is_act;
  logic        k_ok;
  logic        wr_ok;
  logic        k_last;
  logic        row_done;
  logic        last_row;
  logic        last_matrix;

  logic signed [37:0] fifo_mem [MAX_COLS];

  wsm_pkg::tok_t  tok_link [MAX_COLS+1];
  wsm_pkg::link_t res_link [MAX_COLS+1];

  assign cfg_ready = 1'b1;
  assign op_stall  = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m      <= 11'd1;
      inner_k     <= 7'd1;
      cols_n      <= 7'd1;
      batch_count <= 11'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsm_pkg::REG_ROWS_M:      rows_m      <= cfg_data;
        wsm_pkg::REG_INNER_K:     inner_k     <= cfg_data[6:0];
        wsm_pkg::REG_COLS_N:      cols_n      <= cfg_data[6:0];
        wsm_pkg::REG_BATCH_COUNT: batch_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp each dimension to its legal range; zero acts as one.
  always_comb begin
    if (inner_k == '0) begin
      kk = 9'd1;
    end else if ({2'b0, inner_k} > 9'(MAX_INNER)) begin
      kk = 9'(MAX_INNER);
    end else begin
      kk = {2'b0, inner_k};
    end
    if (cols_n == '0) begin
      nn = 7'd1;
    end else if (cols_n > 7'(MAX_COLS)) begin
      nn = 7'(MAX_COLS);
    end else begin
      nn = cols_n;
    end
    if (rows_m == '0) begin
      mm = 11'd1;
    end else if (rows_m > 11'(wsm_pkg::DIM_LIMIT)) begin
      mm = 11'(wsm_pkg::DIM_LIMIT);
    end else begin
      mm = rows_m;
    end
    if (batch_count == '0) begin
      bb = 11'd1;
    end else if (batch_count > 11'(wsm_pkg::DIM_LIMIT)) begin
      bb = 11'(wsm_pkg::DIM_LIMIT);
    end else begin
      bb = batch_count;
    end
  end

  assign accept      = op_valid && !op_stall;
  assign is_act      = op.command == wsm_pkg::OP_STREAM;
  assign k_ok        = {3'b0, op.inner_index} < kk;
  assign k_last      = {3'b0, op.inner_index} == (kk - 9'd1);
  assign wr_ok       = ({3'b0, op.inner_index} < 9'(MAX_INNER)) &&
                       ({1'b0, op.column_index} < 7'(MAX_COLS));
  assign row_done    = accept && is_act && k_ok && k_last;
  assign last_row    = {1'b0, row_counter} >= (mm - 11'd1);
  assign last_matrix = {1'b0, matrix_counter} >= (bb - 11'd1);

  // Chain entry: drop stream elements past inner_k and writes outside B.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_link[0].valid <= 1'b0;
    end else begin
      tok_link[0].valid <= accept && (is_act ? k_ok : wr_ok);
    end
  end

  always_ff @(posedge clk) begin
    tok_link[0].write <= !is_act;
    tok_link[0].last  <= k_last;
    tok_link[0].k     <= {2'b0, op.inner_index};
    tok_link[0].col   <= op.column_index;
    tok_link[0].value <= op.operand_value;
  end

  assign res_link[MAX_COLS] = '0;

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    wsm_cell #(
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS),
      .COL       (j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ncols   (nn),
      .tok_in  (tok_link[j]),
      .tok_out (tok_link[j+1]),
      .res_in  (res_link[j+1]),
      .res_out (res_link[j])
    );
  end

  // Row and matrix counters advance when a row closes; tag the row then.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      matrix_counter <= '0;
      busy           <= 1'b0;
      rcv_cnt        <= '0;
      rd_col         <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (row_done) begin
        busy    <= 1'b1;
        rcv_cnt <= '0;
        rd_col  <= '0;
        if (last_row) begin
          row_counter    <= '0;
          matrix_counter <= last_matrix ? 10'd0 : matrix_counter + 10'd1;
        end else begin
          row_counter <= row_counter + 10'd1;
        end
      end else begin
        if (busy && rd_col == nn && !res_valid) begin
          busy <= 1'b0;
        end
        if (res_link[0].valid) begin
          rcv_cnt <= rcv_cnt + 7'd1;
        end
        if (load) begin
          rd_col <= rd_col + 7'd1;
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      row_tag   <= row_counter;
      batch_end <= last_row && last_matrix;
    end
  end

  // Result buffer: sums arrive in column order; hold them while res stalls.
  assign load = (rcv_cnt != rd_col) && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (res_link[0].valid) begin
      fifo_mem[rcv_cnt[AW-1:0]] <= res_link[0].sum;
    end
    if (load) begin
      res.product_sum   <= fifo_mem[rd_col[AW-1:0]];
      res.out_row       <= row_tag;
      res.out_column    <= rd_col[5:0];
      res.last_of_row   <= rd_col == (nn - 7'd1);
      res.last_of_batch <= (rd_col == (nn - 7'd1)) && batch_end;
    end
  end

`ifndef SYNTHESIS
  // Sums only come back while a row is being drained.
  a_res_in_row: assert property (@(posedge clk) disable iff (rst)
    res_link[0].valid |-> busy)
    else $error("column sum arrived outside a row drain");

  // Never read a sum that has not arrived.
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    rd_col <= rcv_cnt)
    else $error("result buffer read ahead of write");

  // A row being drained never yields more sums than columns.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    busy |-> rcv_cnt <= nn)
    else $error("more column sums than columns");

  // A closing request blocks further input until its row drains.
  a_row_blocks: assert property (@(posedge clk) disable iff (rst)
    row_done |=> busy)
    else $error("row close did not stall the input");

  // Every request that enters the chain leaves its far end in order.
  a_chain_flow: assert property (@(posedge clk) disable iff (rst)
    tok_link[0].valid |-> ##(MAX_COLS) tok_link[MAX_COLS].valid)
    else $error("request lost in the cell chain");
`endif

endmodule
`default_nettype wire

// File: tb/sv/weight_stationary_matmul_tb.sv
`timescale 1ns / 1ps
module weight_stationary_matmul_tb;

  localparam int MAX_K         = 64;
  localparam int MAX_N         = 64;
  localparam int DIM_CAP       = 1024;
  // Quiet time after the last sum: lets write requests and open rows
  // finish their walk down the cell chain before a register changes.
  localparam int SETTLE_CYCLES = 2 * MAX_N + 40;
  localparam int LONG_HOLD     = 400;
  localparam int TARGET_ITEMS  = 370;
  localparam int SMALL_PHASES  = 2;

  logic          clk;
  logic          rst = 1'b1;
  logic          op_valid = 1'b0;
  logic          op_stall;
  wsm_pkg::op_t  op = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  wsm_pkg::out_t res;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = wsm_pkg::REG_ROWS_M;
  logic [10:0]   cfg_data = '0;

  weight_stationary_matmul dut (
    .clk(clk),
    .rst(rst),
    .op_valid(op_valid),
    .op_stall(op_stall),
    .op(op),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout: far beyond the slowest legal run, with every row emitting
  // 64 sums and both sides idling as long as they may.
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: B table, column sums, counters and registers.
  // ---------------------------------------------------------------------
  logic signed [15:0] weight_tab [MAX_K][MAX_N];
  logic signed [37:0] col_sum [MAX_N];
  logic [9:0]         row_num;
  logic [9:0]         matrix_num;
  logic [10:0]        rows_reg;
  logic [6:0]         inner_reg;
  logic [6:0]         cols_reg;
  logic [10:0]        batch_reg;

  wsm_pkg::out_t pending_sums [$];   // column sums the block still owes, oldest first
  wsm_pkg::op_t  op_backlog [$];     // requests waiting to be offered
  bit            weight_loaded [MAX_K][MAX_N];

  int  check_errors = 0;
  int  sums_checked = 0;
  int  requests_taken = 0;
  int  rows_closed = 0;
  int  items_planned = 0;
  int  phases_run = 0;
  bit  no_idle = 1'b0;
  int  send_gap = 0;
  int  recv_wait = 0;
  int  hold_left = 0;
  int  hold_epoch = 0;
  int  hold_seen = 0;

  // Registers act clamped to 1..hi, so zero behaves as one.
  function automatic int dim_used(input int raw, input int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Apply one accepted request to the shadow and queue the sums it closes.
  task automatic accumulate_request(input wsm_pkg::op_t req);
    int                 kk;
    int                 nn;
    int                 k;
    logic signed [37:0] a_ext;
    logic signed [37:0] w_ext;
    logic               row_done;
    logic               batch_done;
    wsm_pkg::out_t      sum_out;
    kk = dim_used(inner_reg, MAX_K);
    nn = dim_used(cols_reg, MAX_N);
    k = req.inner_index;
    if (req.command == wsm_pkg::OP_WRITE) begin
      weight_tab[k][req.column_index] = req.operand_value;
      return;
    end
    // Drop an A element whose index lies past inner_k.
    if (k >= kk) return;
    a_ext = $signed(req.operand_value);
    for (int j = 0; j < nn; j++) begin
      w_ext = weight_tab[k][j];
      col_sum[j] = col_sum[j] + a_ext * w_ext;   // wraps modulo 2^38
    end
    if (k != kk - 1) return;
    // Last inner index: emit the row, then clear every column sum.
    row_done = (row_num >= dim_used(rows_reg, DIM_CAP) - 1);
    batch_done = (matrix_num >= dim_used(batch_reg, DIM_CAP) - 1);
    for (int j = 0; j < nn; j++) begin
      sum_out.product_sum = col_sum[j];
      sum_out.out_row = row_num;
      sum_out.out_column = 6'(j);
      sum_out.last_of_row = (j == nn - 1);
      sum_out.last_of_batch = (j == nn - 1) && row_done && batch_done;
      pending_sums.push_back(sum_out);
    end
    foreach (col_sum[j]) col_sum[j] = '0;
    rows_closed++;
    // A counter left past its limit by a register change wraps here.
    if (row_done) begin
      row_num = '0;
      matrix_num = batch_done ? 10'd0 : matrix_num + 10'd1;
    end else begin
      row_num = row_num + 10'd1;
    end
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      check_errors++;
    end
  endtask

  task automatic check_sum(input wsm_pkg::out_t got);
    wsm_pkg::out_t want;
    if (pending_sums.size() == 0) begin
      $error("unexpected result: row %0d column %0d sum %0d",
             got.out_row, got.out_column, $signed(got.product_sum));
      check_errors++;
      return;
    end
    want = pending_sums.pop_front();
    sums_checked++;
    compare_field("product_sum", $signed(want.product_sum), $signed(got.product_sum));
    compare_field("out_row", want.out_row, got.out_row);
    compare_field("out_column", want.out_column, got.out_column);
    compare_field("last_of_row", want.last_of_row, got.last_of_row);
    compare_field("last_of_batch", want.last_of_batch, got.last_of_batch);
  endtask

  // ---------------------------------------------------------------------
  // Driver: take a request when valid and not stalled, hold the payload
  // while stalled, then wait a drawn number of cycles before the next one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (op_valid && !op_stall) begin
        accumulate_request(op);
        requests_taken++;
        send_gap = draw_wait();
      end
      if (!(op_valid && op_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          op_valid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          op <= op_backlog.pop_front();
          op_valid <= 1'b1;
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check every accepted sum, then stall a drawn number of
  // cycles. A new hold epoch starts a long hold-off counted here.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_epoch != hold_seen) begin
        hold_seen = hold_epoch;
        hold_left = LONG_HOLD;
      end
      if (res_valid && !res_stall) begin
        check_sum(res);
        recv_wait = draw_wait();
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic plan_request(input logic cmd, input int k, input int c,
                              input logic [15:0] v);
    wsm_pkg::op_t r;
    r.command = cmd;
    r.inner_index = 6'(k);
    r.column_index = 6'(c);
    r.operand_value = v;
    op_backlog.push_back(r);
    items_planned++;
    if (cmd == wsm_pkg::OP_WRITE) weight_loaded[k][c] = 1'b1;
  endtask

  // Queue one A element; load any B entry of its row that it would read
  // before it was ever written.
  task automatic plan_stream(input int k, input logic [15:0] v);
    int nn;
    nn = dim_used(cols_reg, MAX_N);
    if (k < dim_used(inner_reg, MAX_K)) begin
      for (int j = 0; j < nn; j++) begin
        if (!weight_loaded[k][j]) plan_request(wsm_pkg::OP_WRITE, k, j, pick_operand());
      end
    end
    plan_request(wsm_pkg::OP_STREAM, k, $urandom_range(0, 63), v);
  endtask

  // Mostly well-formed rows; the rest reordered, repeated, gapped, padded
  // with dropped indices and a B rewrite, or left open into the next row.
  task automatic plan_row();
    int kk;
    int style;
    kk = dim_used(inner_reg, MAX_K);
    style = $urandom_range(0, 9);
    if (style < 6) begin
      for (int k = 0; k < kk; k++) plan_stream(k, pick_operand());
    end else if (style == 6) begin
      for (int k = kk - 2; k >= 0; k--) plan_stream(k, pick_operand());
      plan_stream(kk - 1, pick_operand());
    end else if (style == 7) begin
      if (kk > 1) begin
        repeat ($urandom_range(1, kk + 2)) plan_stream($urandom_range(0, kk - 2),
                                                       pick_operand());
      end
      plan_stream(kk - 1, pick_operand());
    end else if (style == 8) begin
      if (kk < MAX_K) plan_stream($urandom_range(kk, 63), pick_operand());
      plan_request(wsm_pkg::OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                   pick_operand());
      for (int k = 0; k < kk; k++) plan_stream(k, pick_operand());
    end else if (kk > 1) begin
      plan_stream($urandom_range(0, kk - 2), pick_operand());
    end
  endtask

  // Hold until the backlog is offered, every sum has come and the chain
  // has gone quiet.
  task automatic wait_idle();
    do @(negedge clk);
    while (op_backlog.size() != 0 || op_valid || pending_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      wsm_pkg::REG_ROWS_M:      rows_reg = val;
      wsm_pkg::REG_INNER_K:     inner_reg = val[6:0];
      wsm_pkg::REG_COLS_N:      cols_reg = val[6:0];
      wsm_pkg::REG_BATCH_COUNT: batch_reg = val;
      default: ;
    endcase
  endtask

  task automatic start_phase(input logic [10:0] rows, input logic [10:0] inner,
                             input logic [10:0] cols, input logic [10:0] batch,
                             input bit quiet);
    wait_idle();
    write_reg(wsm_pkg::REG_ROWS_M, rows);
    write_reg(wsm_pkg::REG_INNER_K, inner);
    write_reg(wsm_pkg::REG_COLS_N, cols);
    write_reg(wsm_pkg::REG_BATCH_COUNT, batch);
    @(negedge clk);
    no_idle = quiet;
    phases_run++;
  endtask

  task automatic plan_random_phase();
    logic [10:0] rows;
    logic [10:0] inner;
    logic [10:0] cols;
    logic [10:0] batch;
    int          n_rows;
    rows = $urandom_range(0, 4);
    batch = $urandom_range(0, 3);
    inner = $urandom_range(0, 6);
    cols = $urandom_range(0, 9);
    // Bits above the 7-bit registers must be dropped by the block.
    if ($urandom_range(0, 3) == 0) begin
      inner[10:7] = 4'($urandom);
      cols[10:7] = 4'($urandom);
    end
    if ($urandom_range(0, 7) == 0) rows = 11'($urandom);
    if ($urandom_range(0, 7) == 0) batch = 11'($urandom);
    n_rows = $urandom_range(2, 7);
    start_phase(rows, inner, cols, batch, $urandom_range(0, 3) == 0);
    repeat (n_rows) plan_row();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int small_done;
    foreach (weight_tab[k, j]) weight_tab[k][j] = '0;
    foreach (col_sum[j]) col_sum[j] = '0;
    row_num = '0;
    matrix_num = '0;
    rows_reg = 11'd1;
    inner_reg = 7'd1;
    cols_reg = 7'd1;
    batch_reg = 11'd1;
    small_done = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes 1x1x1: operand extremes, dropped index, far B corner.
    plan_request(wsm_pkg::OP_WRITE, 0, 0, 16'h7FFF);
    plan_stream(0, 16'h7FFF);
    plan_request(wsm_pkg::OP_WRITE, 0, 0, 16'h8000);
    plan_stream(0, 16'h8000);
    plan_stream(0, 16'h7FFF);
    plan_stream(0, 16'h0000);
    plan_stream(37, 16'h5A5A);
    plan_request(wsm_pkg::OP_WRITE, 63, 63, 16'hFFFF);
    plan_request(wsm_pkg::OP_WRITE, 42, 21, 16'h1234);
    plan_stream(0, 16'hFFFF);

    // Zero registers act as one; inner_k carries only dropped high bits.
    start_phase(11'd0, 11'h780, 11'd0, 11'd0, 1'b0);
    plan_stream(0, 16'h1234);
    plan_stream(1, 16'h4321);

    // 2x3 by 3x2, batch of two: out-of-order, repeated and missing indices.
    start_phase(11'd2, 11'd3, 11'd2, 11'd2, 1'b0);
    plan_stream(1, pick_operand());
    plan_stream(0, pick_operand());
    plan_stream(2, pick_operand());
    plan_stream(0, pick_operand());
    plan_stream(0, pick_operand());
    plan_stream(2, pick_operand());

    // Push column sums past the 38-bit range with repeated max products.
    start_phase(11'd3, 11'd2, 11'd2, 11'd2, 1'b1);
    plan_request(wsm_pkg::OP_WRITE, 0, 0, 16'h8000);
    plan_request(wsm_pkg::OP_WRITE, 0, 1, 16'h7FFF);
    repeat (129) plan_stream(0, 16'h8000);
    plan_stream(1, pick_operand());

    // Deepest inner dimension, then a clamped inner_k closing on its last index.
    start_phase(11'd4, 11'd64, 11'd1, 11'd3, 1'b0);
    for (int k = 0; k < MAX_K; k++) plan_stream(k, pick_operand());
    start_phase(11'd4, 11'd127, 11'd1, 11'd3, 1'b0);
    plan_stream(63, pick_operand());
    plan_stream(5, pick_operand());

    // Widest rows with largest rows_m and batch_count; hold the receiver off
    // long enough that the block stalls the sender.
    start_phase(11'h7FF, 11'd1, 11'd64, 11'd1024, 1'b1);
    hold_epoch <= hold_epoch + 1;
    repeat (6) plan_stream(0, pick_operand());

    // Clamped cols_n; the row counter sits past the new rows_m and wraps.
    start_phase(11'd1, 11'd0, 11'd100, 11'd1, 1'b0);
    plan_stream(0, pick_operand());
    plan_stream(0, pick_operand());

    while (items_planned < TARGET_ITEMS || small_done < SMALL_PHASES) begin
      plan_random_phase();
      small_done++;
    end

    wait_idle();
    $display("Run: %0d requests over %0d register settings, %0d rows closed,",
             requests_taken, phases_run + 1, rows_closed);
    $display("     %0d column sums compared, %0d mismatches.", sums_checked, check_errors);
    if (check_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
